// ----- hdl/bmc_pkg.sv -----
// Shared types and constants of the 3x3 cross binary morphology block.
package bmc_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int MODE_W     = 2;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MIN_SIZE   = 3;

  localparam logic [PIX_W-1:0] PIX_SET = 8'd255;
  localparam logic [PIX_W-1:0] PIX_CLR = 8'd0;

  localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOUNDARY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_end;
  } out_item_t;

endpackage

// ----- hdl/bmc_stream_if.sv -----
// Request channels of the morphology block: pixel input and result output.
interface bmc_in_if
  import bmc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;

  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface bmc_out_if
  import bmc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             frame_end;

  modport source (output valid, pixel_out, out_row, out_col, frame_end, input ready);
  modport sink   (input valid, pixel_out, out_row, out_col, frame_end, output ready);
endinterface

// ----- hdl/binary_morphology_cross3x3.sv -----
// Binary morphology with a 3x3 cross element: dilation, erosion or boundary.
//
// Takes one pixel and returns one result per clock in raster order while both
// ready signals are high; a result passes stage 1 and the output queue. Both
// line buffers share one RAM entry per column, read in the cycle a pixel is
// taken and written back in the next, with forwarding when the same column is
// touched twice in a row. After reset the RAM is swept to zero, during which no
// pixel is taken; configuration writes are taken at any time. Pixels in row 0 or
// column 0 give no result; a result for (r-1,c-1) follows the pixel at (r,c).
module binary_morphology_cross3x3
  import bmc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bmc_in_if.sink                in_s,
  bmc_out_if.source             out_m,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int WSWA = $clog2(MAX_WIDTH + 1);
  localparam int HSWA = $clog2(MAX_HEIGHT + 1);
  localparam int WSW  = (WSWA > SIZE_W) ? WSWA : SIZE_W;
  localparam int HSW  = (HSWA > SIZE_W) ? HSWA : SIZE_W;

  // configuration
  logic [MODE_W-1:0] mode_r;
  logic [SIZE_W-1:0] frame_width_r;
  logic [SIZE_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_DILATE;
      frame_width_r  <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode_r         <= cfg_data[MODE_W-1:0];
        REG_WIDTH:  frame_width_r  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: frame_height_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WSW-1:0] fw, fw_raw;
  logic [HSW-1:0] fh, fh_raw;

  assign fw_raw = WSW'(frame_width_r);
  assign fh_raw = HSW'(frame_height_r);

  always_comb begin
    priority if (fw_raw < WSW'(MIN_SIZE)) begin
      fw = WSW'(MIN_SIZE);
    end else if (fw_raw > WSW'(MAX_WIDTH)) begin
      fw = WSW'(MAX_WIDTH);
    end else begin
      fw = fw_raw;
    end
    priority if (fh_raw < HSW'(MIN_SIZE)) begin
      fh = HSW'(MIN_SIZE);
    end else if (fh_raw > HSW'(MAX_HEIGHT)) begin
      fh = HSW'(MAX_HEIGHT);
    end else begin
      fh = fh_raw;
    end
  end

  // clearing sweep
  logic          clr_busy_r;
  logic [XW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + XW'(1);
      if (clr_addr_r == XW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // output queue, two entries
  out_item_t q0_r, q1_r;
  logic [1:0] q_cnt_r;
  logic       push, pop;
  out_item_t  new_item;
  logic [2:0] occ;
  logic       s1_valid_r;

  assign pop = (q_cnt_r != 2'd0) && out_m.ready;
  assign occ = {1'b0, q_cnt_r} + {2'b00, s1_valid_r};

  // input side
  logic in_acc;
  assign in_s.ready = !clr_busy_r && (occ <= (3'd1 + {2'b00, pop}));
  assign in_acc     = in_s.valid && in_s.ready;

  logic [YW-1:0] row_cnt_r, r_sel, r_pos, r_next;
  logic [XW-1:0] col_cnt_r, c_sel, c_pos, c_next;
  logic [WSW-1:0] c_inc;
  logic [HSW-1:0] r_inc;
  logic           emit0, border0, last0;

  always_comb begin
    r_sel = in_s.frame_start ? '0 : row_cnt_r;
    c_sel = in_s.frame_start ? '0 : col_cnt_r;
    if ((HSW'(r_sel) >= fh) || (WSW'(c_sel) >= fw)) begin
      r_pos = '0;
      c_pos = '0;
    end else begin
      r_pos = r_sel;
      c_pos = c_sel;
    end
    c_inc = WSW'(c_pos) + WSW'(1);
    r_inc = HSW'(r_pos) + HSW'(1);
    if (c_inc >= fw) begin
      c_next = '0;
      r_next = (r_inc >= fh) ? '0 : r_inc[YW-1:0];
    end else begin
      c_next = c_inc[XW-1:0];
      r_next = r_pos;
    end
    emit0   = (r_pos != '0) && (c_pos != '0);
    border0 = (r_pos == YW'(1)) || (c_pos == XW'(1));
    last0   = (HSW'(r_pos) == fh - HSW'(1)) && (WSW'(c_pos) == fw - WSW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_acc) begin
      row_cnt_r <= r_next;
      col_cnt_r <= c_next;
    end
  end

  // stage 1: RAM data back, window update, result
  logic          s1_cur_r, s1_emit_r, s1_border_r, s1_last_r;
  logic [XW-1:0] s1_addr_r, s1_col_r;
  logic [YW-1:0] s1_row_r;
  logic          fwd_r;
  logic [1:0]    fwd_data_r;
  logic [3:0]    win_r;

  logic [1:0]    rd_data, ent, wr_data;
  logic          above, above2, top, ctr, left, bot, dil, ero, res;
  logic          ram_we;
  logic [XW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;

  assign ent     = fwd_r ? fwd_data_r : rd_data;
  assign above   = ent[0];
  assign above2  = ent[1];
  assign wr_data = {above, s1_cur_r};

  assign top  = win_r[0];
  assign ctr  = win_r[1];
  assign left = win_r[2];
  assign bot  = win_r[3];
  assign dil  = top | left | ctr | above | bot;
  assign ero  = top & left & ctr & above & bot;

  always_comb begin
    unique case (mode_r)
      MODE_DILATE:   res = dil;
      MODE_ERODE:    res = ero;
      MODE_BOUNDARY: res = ctr & ~ero;
      default:       res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      s1_valid_r <= in_acc;
      if (s1_valid_r) begin
        win_r <= {s1_cur_r, ctr, above, above2};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r    <= (in_s.pixel_in != '0);
      s1_addr_r   <= c_pos;
      s1_emit_r   <= emit0;
      s1_border_r <= border0;
      s1_last_r   <= last0;
      s1_row_r    <= r_pos - YW'(1);
      s1_col_r    <= c_pos - XW'(1);
      fwd_r       <= s1_valid_r && (s1_addr_r == c_pos);
      fwd_data_r  <= wr_data;
    end
  end

  assign ram_we    = clr_busy_r || s1_valid_r;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_busy_r ? 2'b00 : wr_data;

  bmc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (c_pos),
    .rdata (rd_data)
  );

  assign push                = s1_valid_r && s1_emit_r;
  assign new_item.pixel_out  = (!s1_border_r && res) ? PIX_SET : PIX_CLR;
  assign new_item.out_row    = ROW_W'(s1_row_r);
  assign new_item.out_col    = COL_W'(s1_col_r);
  assign new_item.frame_end  = s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      unique case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 2'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (q_cnt_r == 2'd0) begin
          q0_r <= new_item;
        end else begin
          q1_r <= new_item;
        end
      end
      2'b01: begin
        q0_r <= q1_r;
      end
      2'b11: begin
        if (q_cnt_r == 2'd1) begin
          q0_r <= new_item;
        end else begin
          q0_r <= q1_r;
          q1_r <= new_item;
        end
      end
      default: ;
    endcase
  end

  assign out_m.valid     = (q_cnt_r != 2'd0);
  assign out_m.pixel_out = q0_r.pixel_out;
  assign out_m.out_row   = q0_r.out_row;
  assign out_m.out_col   = q0_r.out_col;
  assign out_m.frame_end = q0_r.frame_end;

  // checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("output queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_cnt_r != 2'd2) || pop)
    else $error("result pushed into a full queue");

  a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted pixel did not reach the RAM stage");

  a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_valid_r && !push)
    else $error("pixel in flight during RAM clear");

endmodule

// ----- hdl/bmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bmc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
